// ===== src/tdq_pkg.sv =====
// shared types and constants of the timed task dispatch queue
package tdq_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned DELTA_W   = 16;
  localparam int unsigned TASK_ID_W = 8;
  localparam int unsigned RES_MAX   = 16;
  localparam int unsigned RES_W     = $clog2(RES_MAX);

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACCEPT   = 2'd0,
    KIND_REJECT   = 2'd1,
    KIND_DISPATCH = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_PICK,
    ST_PUSH
  } state_e;

  // per-cell control from the sequencer
  typedef struct packed {
    logic live;
    logic load;
    logic prep;
    logic bump;
    logic shift;
  } cell_ctl_t;

endpackage

// ===== src/tdq_if.sv =====
// handshake channels of the timed task dispatch queue
interface tdq_in_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic [tdq_pkg::TASK_ID_W-1:0]     task_id;
  logic [tdq_pkg::DELTA_W-1:0]       delay;
  logic [tdq_pkg::DELTA_W-1:0]       period;

  modport source (output valid, mode, task_id, delay, period, input ready);
  modport sink   (input valid, mode, task_id, delay, period, output ready);
endinterface

interface tdq_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        kind;
  logic [tdq_pkg::TASK_ID_W-1:0]     task_id_res;
  logic [tdq_pkg::TIME_W-1:0]        due_time;
  logic                              recurring;
  logic                              last;

  modport source (output valid, kind, task_id_res, due_time, recurring, last, input ready);
  modport sink   (input valid, kind, task_id_res, due_time, recurring, last, output ready);
endinterface

// ===== src/tdq_cell.sv =====
// one queue cell: holds a task entry and passes the running best candidate on
module tdq_cell #(
  parameter int unsigned IdBits = 8,
  parameter int unsigned SlotW  = 4
) (
  input  logic                            clk_i,
  input  tdq_pkg::cell_ctl_t              ctl_i,
  input  logic [SlotW-1:0]                slot_i,
  input  logic [tdq_pkg::TIME_W-1:0]      now_i,
  input  logic [IdBits-1:0]               new_id_i,
  input  logic [tdq_pkg::TIME_W-1:0]      new_due_i,
  input  logic [tdq_pkg::DELTA_W-1:0]     new_per_i,
  input  logic [IdBits-1:0]               nb_id_i,
  input  logic [tdq_pkg::TIME_W-1:0]      nb_due_i,
  input  logic [tdq_pkg::DELTA_W-1:0]     nb_per_i,
  input  logic [tdq_pkg::TIME_W-1:0]      nb_key_i,
  input  logic                            nb_pend_i,
  output logic [IdBits-1:0]               id_o,
  output logic [tdq_pkg::TIME_W-1:0]      due_o,
  output logic [tdq_pkg::DELTA_W-1:0]     per_o,
  output logic [tdq_pkg::TIME_W-1:0]      key_o,
  output logic                            pend_o,
  input  logic                            ci_found_i,
  input  logic [tdq_pkg::TIME_W-1:0]      ci_key_i,
  input  logic [IdBits-1:0]               ci_id_i,
  input  logic [tdq_pkg::TIME_W-1:0]      ci_due_i,
  input  logic [tdq_pkg::DELTA_W-1:0]     ci_per_i,
  input  logic [SlotW-1:0]                ci_slot_i,
  output logic                            co_found_o,
  output logic [tdq_pkg::TIME_W-1:0]      co_key_o,
  output logic [IdBits-1:0]               co_id_o,
  output logic [tdq_pkg::TIME_W-1:0]      co_due_o,
  output logic [tdq_pkg::DELTA_W-1:0]     co_per_o,
  output logic [SlotW-1:0]                co_slot_o
);

  logic [IdBits-1:0]               id_q, id_d;
  logic [tdq_pkg::TIME_W-1:0]      due_q, due_d;
  logic [tdq_pkg::DELTA_W-1:0]     per_q, per_d;
  logic [tdq_pkg::TIME_W-1:0]      key_q, key_d;
  logic                            pend_q, pend_d;
  logic [tdq_pkg::TIME_W-1:0]      diff;
  logic                            own_wins;

  logic                            cf_q, cf_d;
  logic [tdq_pkg::TIME_W-1:0]      ck_q, ck_d;
  logic [IdBits-1:0]               cid_q, cid_d;
  logic [tdq_pkg::TIME_W-1:0]      cdue_q, cdue_d;
  logic [tdq_pkg::DELTA_W-1:0]     cper_q, cper_d;
  logic [SlotW-1:0]                cslot_q, cslot_d;

  always_comb begin
    diff   = due_q - now_i;
    id_d   = id_q;
    due_d  = due_q;
    per_d  = per_q;
    key_d  = key_q;
    pend_d = pend_q;
    if (ctl_i.load) begin
      id_d  = new_id_i;
      due_d = new_due_i;
      per_d = new_per_i;
    end
    // due when the wrapped distance to now is zero or negative
    if (ctl_i.prep) begin
      key_d  = diff;
      pend_d = ctl_i.live & (diff[tdq_pkg::TIME_W-1] | (diff == '0));
    end
    if (ctl_i.bump) begin
      due_d  = due_q + tdq_pkg::TIME_W'(per_q);
      pend_d = 1'b0;
    end
    // close the gap left by a removed entry
    if (ctl_i.shift) begin
      id_d   = nb_id_i;
      due_d  = nb_due_i;
      per_d  = nb_per_i;
      key_d  = nb_key_i;
      pend_d = nb_pend_i;
    end
  end

  // earlier slots come in from the left, so a full tie keeps the incoming one
  always_comb begin
    own_wins = pend_q & (~ci_found_i
                         | ($signed(key_q) < $signed(ci_key_i))
                         | ((key_q == ci_key_i) & (id_q < ci_id_i)));
    if (own_wins) begin
      cf_d    = 1'b1;
      ck_d    = key_q;
      cid_d   = id_q;
      cdue_d  = due_q;
      cper_d  = per_q;
      cslot_d = slot_i;
    end else begin
      cf_d    = ci_found_i;
      ck_d    = ci_key_i;
      cid_d   = ci_id_i;
      cdue_d  = ci_due_i;
      cper_d  = ci_per_i;
      cslot_d = ci_slot_i;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    due_q   <= due_d;
    per_q   <= per_d;
    key_q   <= key_d;
    pend_q  <= pend_d;
    cf_q    <= cf_d;
    ck_q    <= ck_d;
    cid_q   <= cid_d;
    cdue_q  <= cdue_d;
    cper_q  <= cper_d;
    cslot_q <= cslot_d;
  end

  assign id_o       = id_q;
  assign due_o      = due_q;
  assign per_o      = per_q;
  assign key_o      = key_q;
  assign pend_o     = pend_q;
  assign co_found_o = cf_q;
  assign co_key_o   = ck_q;
  assign co_id_o    = cid_q;
  assign co_due_o   = cdue_q;
  assign co_per_o   = cper_q;
  assign co_slot_o  = cslot_q;

endmodule

// ===== src/timed_task_dispatch_queue.sv =====
// top level of the timed task dispatch queue: sequencer, tick counter and cell chain
//
//   channel   dir  handshake           payload
//   in_i      in   valid/ready         mode, task_id, delay, period
//   out_o     out  valid/ready         kind, task_id_res, due_time, recurring, last
//   cfg       in   cfg_we_i, no wait   cfg_wdata_i (dispatch_enable)
//
// an add is registered in the hold register, then copied to the output register once that is free
// a tick advances time, then with dispatch enabled a prep step plus one search of
// the cell chain (scan, then pick) per dispatched task and one empty search that releases the
// final beat (the push state instead after the sixteenth); at most 16 beats per tick
// rst_ni clears time, fill count, sequencer and output valid; enable resets to 1
// a stalled output holds the sequencer at its next beat, the cells keep their state
module timed_task_dispatch_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tdq_in_if.sink           in_i,
  tdq_out_if.source        out_o,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i
);

  localparam int unsigned SlotW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TW    = tdq_pkg::TIME_W;
  localparam int unsigned DW    = tdq_pkg::DELTA_W;

  tdq_pkg::state_e               state_q, state_d;
  logic [TW-1:0]                 now_q;
  logic [CntW-1:0]               count_q;
  logic                          en_q;
  logic [SlotW-1:0]              scan_q;
  logic [tdq_pkg::RES_W-1:0]     nsel_q;
  logic                          have_hold_q;

  // result waiting for the output register
  tdq_pkg::kind_e                hold_kind_q;
  logic [tdq_pkg::TASK_ID_W-1:0] hold_id_q;
  logic [TW-1:0]                 hold_due_q;
  logic                          hold_rec_q;

  // output register
  logic                          out_valid_q;
  tdq_pkg::kind_e                out_kind_q;
  logic [tdq_pkg::TASK_ID_W-1:0] out_id_q;
  logic [TW-1:0]                 out_due_q;
  logic                          out_rec_q;
  logic                          out_last_q;

  // sequencer strobes
  logic in_ready;
  logic acc_add;
  logic acc_tick;
  logic do_prep;
  logic do_upd;
  logic push;
  logic push_last;
  logic out_free;
  logic full;

  // chain wiring: entries read from the right, candidates ripple to the right
  logic [ID_BITS-1:0]    e_id   [QUEUE_DEPTH+1];
  logic [TW-1:0]         e_due  [QUEUE_DEPTH+1];
  logic [DW-1:0]         e_per  [QUEUE_DEPTH+1];
  logic [TW-1:0]         e_key  [QUEUE_DEPTH+1];
  logic                  e_pend [QUEUE_DEPTH+1];
  logic                  c_found[QUEUE_DEPTH+1];
  logic [TW-1:0]         c_key  [QUEUE_DEPTH+1];
  logic [ID_BITS-1:0]    c_id   [QUEUE_DEPTH+1];
  logic [TW-1:0]         c_due  [QUEUE_DEPTH+1];
  logic [DW-1:0]         c_per  [QUEUE_DEPTH+1];
  logic [SlotW-1:0]      c_slot [QUEUE_DEPTH+1];
  tdq_pkg::cell_ctl_t    ctl    [QUEUE_DEPTH];

  logic                  w_found;
  logic                  w_rec;
  logic [CntW-1:0]       tgt;
  logic [ID_BITS-1:0]    new_id;
  logic [TW-1:0]         add_due;

  assign full     = (count_q == CntW'(QUEUE_DEPTH));
  assign out_free = ~out_valid_q | out_o.ready;
  assign w_found  = c_found[QUEUE_DEPTH];
  assign w_rec    = (c_per[QUEUE_DEPTH] != '0);
  assign new_id   = ID_BITS'(in_i.task_id);
  assign add_due  = now_q + TW'(in_i.delay);
  // an add appends at the fill count, a dispatch works on the winning slot
  assign tgt      = (state_q == tdq_pkg::ST_IDLE) ? count_q : CntW'(c_slot[QUEUE_DEPTH]);

  // ends of the chain
  assign e_id[QUEUE_DEPTH]   = '0;
  assign e_due[QUEUE_DEPTH]  = '0;
  assign e_per[QUEUE_DEPTH]  = '0;
  assign e_key[QUEUE_DEPTH]  = '0;
  assign e_pend[QUEUE_DEPTH] = 1'b0;
  assign c_found[0]          = 1'b0;
  assign c_key[0]            = '0;
  assign c_id[0]             = '0;
  assign c_due[0]            = '0;
  assign c_per[0]            = '0;
  assign c_slot[0]           = '0;

  // sequencer
  always_comb begin
    state_d   = state_q;
    in_ready  = 1'b0;
    acc_add   = 1'b0;
    acc_tick  = 1'b0;
    do_prep   = 1'b0;
    do_upd    = 1'b0;
    push      = 1'b0;
    push_last = 1'b0;
    unique case (state_q)
      tdq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          if (in_i.mode == tdq_pkg::MODE_TICK) begin
            acc_tick = 1'b1;
            state_d  = en_q ? tdq_pkg::ST_PREP : tdq_pkg::ST_IDLE;
          end else begin
            acc_add = 1'b1;
            state_d = tdq_pkg::ST_PUSH;
          end
        end
      end
      tdq_pkg::ST_PREP: begin
        do_prep = 1'b1;
        state_d = tdq_pkg::ST_SCAN;
      end
      tdq_pkg::ST_SCAN: begin
        if (scan_q == SlotW'(QUEUE_DEPTH - 1)) begin
          state_d = tdq_pkg::ST_PICK;
        end
      end
      tdq_pkg::ST_PICK: begin
        // the held task is only known to be last once the next search comes up empty or it is the sixteenth
        if (~have_hold_q | out_free) begin
          if (have_hold_q) begin
            push      = 1'b1;
            push_last = ~w_found;
          end
          if (w_found) begin
            do_upd  = 1'b1;
            state_d = (nsel_q == tdq_pkg::RES_W'(tdq_pkg::RES_MAX - 1)) ?
                      tdq_pkg::ST_PUSH : tdq_pkg::ST_SCAN;
          end else begin
            state_d = tdq_pkg::ST_IDLE;
          end
        end
      end
      tdq_pkg::ST_PUSH: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          state_d   = tdq_pkg::ST_IDLE;
        end
      end
      default: state_d = tdq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= '0;
      count_q     <= '0;
      en_q        <= 1'b1;
      scan_q      <= '0;
      nsel_q      <= '0;
      have_hold_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
      if (acc_tick) begin
        now_q <= now_q + TW'(1);
      end
      if (acc_add && !full) begin
        count_q <= count_q + CntW'(1);
      end else if (do_upd && !w_rec) begin
        count_q <= count_q - CntW'(1);
      end
      scan_q <= (state_q == tdq_pkg::ST_SCAN) ? scan_q + SlotW'(1) : '0;
      if (do_prep) begin
        nsel_q <= '0;
      end else if (do_upd) begin
        nsel_q <= nsel_q + tdq_pkg::RES_W'(1);
      end
      if (do_prep) begin
        have_hold_q <= 1'b0;
      end else if (do_upd) begin
        have_hold_q <= 1'b1;
      end else if (push) begin
        have_hold_q <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (acc_add) begin
      hold_kind_q <= full ? tdq_pkg::KIND_REJECT : tdq_pkg::KIND_ACCEPT;
      hold_id_q   <= tdq_pkg::TASK_ID_W'(new_id);
      hold_due_q  <= add_due;
      hold_rec_q  <= 1'b0;
    end else if (do_upd) begin
      hold_kind_q <= tdq_pkg::KIND_DISPATCH;
      hold_id_q   <= tdq_pkg::TASK_ID_W'(c_id[QUEUE_DEPTH]);
      hold_due_q  <= c_due[QUEUE_DEPTH];
      hold_rec_q  <= w_rec;
    end
    if (push) begin
      out_kind_q <= hold_kind_q;
      out_id_q   <= hold_id_q;
      out_due_q  <= hold_due_q;
      out_rec_q  <= hold_rec_q;
      out_last_q <= push_last;
    end
  end

  // cell chain, slot 0 holds the oldest entry
  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    logic [CntW-1:0] idx;
    assign idx          = CntW'(k);
    assign ctl[k].live  = (idx < count_q);
    assign ctl[k].load  = acc_add & ~full & (idx == tgt);
    assign ctl[k].prep  = do_prep;
    assign ctl[k].bump  = do_upd & w_rec & (idx == tgt);
    // a one-time task leaves; everything behind it moves up one slot
    assign ctl[k].shift = do_upd & ~w_rec & (idx >= tgt);

    tdq_cell #(
      .IdBits (ID_BITS),
      .SlotW  (SlotW)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl[k]),
      .slot_i     (SlotW'(k)),
      .now_i      (now_q),
      .new_id_i   (new_id),
      .new_due_i  (add_due),
      .new_per_i  (in_i.period),
      .nb_id_i    (e_id[k+1]),
      .nb_due_i   (e_due[k+1]),
      .nb_per_i   (e_per[k+1]),
      .nb_key_i   (e_key[k+1]),
      .nb_pend_i  (e_pend[k+1]),
      .id_o       (e_id[k]),
      .due_o      (e_due[k]),
      .per_o      (e_per[k]),
      .key_o      (e_key[k]),
      .pend_o     (e_pend[k]),
      .ci_found_i (c_found[k]),
      .ci_key_i   (c_key[k]),
      .ci_id_i    (c_id[k]),
      .ci_due_i   (c_due[k]),
      .ci_per_i   (c_per[k]),
      .ci_slot_i  (c_slot[k]),
      .co_found_o (c_found[k+1]),
      .co_key_o   (c_key[k+1]),
      .co_id_o    (c_id[k+1]),
      .co_due_o   (c_due[k+1]),
      .co_per_o   (c_per[k+1]),
      .co_slot_o  (c_slot[k+1])
    );
  end

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_kind_q;
  assign out_o.task_id_res = out_id_q;
  assign out_o.due_time    = out_due_q;
  assign out_o.recurring   = out_rec_q;
  assign out_o.last        = out_last_q;

endmodule
